FILE: hdl/tkt_pkg.sv
// ---------------------------------------------------------------------------
// tkt_pkg: shared types and constants of the top-k tracker
// Field widths, mode codes and the command/status groups between the
// controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tkt_pkg;

    localparam int CNT_W           = 5;
    localparam int ID_W            = 32;
    localparam int KEY_W           = 63;
    localparam int MODE_W          = 2;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_DUMP   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic {
        OSEL_STEP  = 1'b0,
        OSEL_ENTRY = 1'b1
    } t_osel;

    typedef struct packed {
        logic  do_insert;
        logic  do_clear;
        logic  out_load;
        t_osel out_sel;
        logic  idx_clr;
        logic  idx_inc;
    } t_cmd;

    typedef struct packed {
        logic fill_zero;
        logic idx_last;
    } t_stat;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] held_count;
        logic [KEY_W-1:0] min_key;
        logic             out_valid;
        logic [ID_W-1:0]  out_id;
        logic [KEY_W-1:0] out_key;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/tkt_if.sv
// ---------------------------------------------------------------------------
// tkt_if: item channels of the top-k tracker
// Input channel (mode, id, key) and result channel, valid/ready each.
// ---------------------------------------------------------------------------
`default_nettype none

interface tkt_in_if
    import tkt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic [KEY_W-1:0]  entry_key;

    modport source (output valid, mode, entry_id, entry_key, input ready);
    modport sink   (input valid, mode, entry_id, entry_key, output ready);
endinterface

interface tkt_out_if
    import tkt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             accepted;
    logic [CNT_W-1:0] held_count;
    logic [KEY_W-1:0] min_key;
    logic             out_valid;
    logic [ID_W-1:0]  out_id;
    logic [KEY_W-1:0] out_key;
    logic             last;

    modport source (output valid, accepted, held_count, min_key, out_valid,
                    out_id, out_key, last, input ready);
    modport sink   (input valid, accepted, held_count, min_key, out_valid,
                    out_id, out_key, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/tkt_ctrl.sv
// ---------------------------------------------------------------------------
// tkt_ctrl: sequencer of the top-k tracker
// Decodes the mode, steps a dump through the entries, owns result valid.
// ---------------------------------------------------------------------------
`default_nettype none

module tkt_ctrl
    import tkt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    output logic                   o_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output t_cmd                   o_cmd,
    input  wire t_stat             i_stat
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    t_cmd   cmd;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd         = '0;
        cmd.out_sel = OSEL_STEP;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && slot_free) begin
                    case (t_mode'(i_mode))
                        MODE_INSERT: begin
                            cmd.do_insert = 1'b1;
                            cmd.out_load  = 1'b1;
                        end
                        MODE_CLEAR: begin
                            cmd.do_clear = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        MODE_DUMP: begin
                            if (i_stat.fill_zero) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_ENTRY;
                    cmd.idx_inc  = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready     = (r_state == S_IDLE) && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

FILE: hdl/tkt_datapath.sv
// ---------------------------------------------------------------------------
// tkt_datapath: sorted entry row of the top-k tracker
// Row of compare cells with shift-insert, fill count, minimum, capacity,
// dump index and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tkt_datapath
    import tkt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    input  wire logic [ID_W-1:0]  i_id,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    output t_result               o_result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [KEY_W-1:0] r_key [MAX_ENTRIES];
    logic [ID_W-1:0]  r_id  [MAX_ENTRIES];
    logic [KEY_W-1:0] n_key [MAX_ENTRIES];
    logic [ID_W-1:0]  n_id  [MAX_ENTRIES];
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [KEY_W-1:0] r_min, n_min;
    logic [CNT_W-1:0] r_cap;
    logic [IDX_W-1:0] r_idx;
    t_result          r_result, n_result;

    logic [MAX_ENTRIES:0] gt;
    logic [CNT_W-1:0]     cap_eff;
    logic                 drop;
    logic                 ins_ok;
    logic                 wr_row;

    // capacity above the row depth acts as the row depth
    assign cap_eff = (32'(r_cap) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : r_cap;
    assign ins_ok  = (cap_eff != '0) && ((r_fill < cap_eff) || (i_key > r_min));
    assign drop    = (r_fill >= cap_eff);
    assign wr_row  = i_cmd.do_insert && ins_ok;

    // gt is a prefix over held entries since the row is sorted
    always_comb begin
        gt = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            gt[i] = (32'(i) < 32'(r_fill)) && (i_key > r_key[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (drop) begin
                // list shifts down by one: front entry falls out
                if (gt[i+1]) begin
                    n_key[i] = r_key[(i+1) % MAX_ENTRIES];
                    n_id[i]  = r_id[(i+1) % MAX_ENTRIES];
                end else if (gt[i]) begin
                    n_key[i] = i_key;
                    n_id[i]  = i_id;
                end else begin
                    n_key[i] = r_key[i];
                    n_id[i]  = r_id[i];
                end
            end else begin
                if (gt[i]) begin
                    n_key[i] = r_key[i];
                    n_id[i]  = r_id[i];
                end else if (i == 0 || gt[(i+MAX_ENTRIES-1) % MAX_ENTRIES]) begin
                    n_key[i] = i_key;
                    n_id[i]  = i_id;
                end else begin
                    n_key[i] = r_key[(i+MAX_ENTRIES-1) % MAX_ENTRIES];
                    n_id[i]  = r_id[(i+MAX_ENTRIES-1) % MAX_ENTRIES];
                end
            end
        end
    end

    always_comb begin
        if (wr_row) begin
            n_fill = drop ? r_fill : r_fill + CNT_W'(1);
            n_min  = n_key[0];
        end else if (i_cmd.do_clear) begin
            n_fill = '0;
            n_min  = '0;
        end else begin
            n_fill = r_fill;
            n_min  = r_min;
        end
    end

    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.idx_last  = (32'(r_idx) + 32'd1 == 32'(r_fill));

    always_comb begin
        n_result = r_result;
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OSEL_ENTRY: begin
                    n_result.accepted   = 1'b0;
                    n_result.held_count = r_fill;
                    n_result.min_key    = r_min;
                    n_result.out_valid  = 1'b1;
                    n_result.out_id     = r_id[r_idx];
                    n_result.out_key    = r_key[r_idx];
                    n_result.last       = o_stat.idx_last;
                end
                default: begin
                    n_result.accepted   = wr_row;
                    n_result.held_count = n_fill;
                    n_result.min_key    = n_min;
                    n_result.out_valid  = 1'b0;
                    n_result.out_id     = '0;
                    n_result.out_key    = '0;
                    n_result.last       = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_min  <= '0;
            r_cap  <= CAP_RESET;
            r_idx  <= '0;
        end else begin
            r_fill <= n_fill;
            r_min  <= n_min;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (wr_row) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_key[i] <= n_key[i];
                r_id[i]  <= n_id[i];
            end
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/top_k_tracker.sv
// ---------------------------------------------------------------------------
// top_k_tracker: keeps the highest-key entries offered, sorted ascending
// Insert, clear and dump items over a valid/ready channel; one capacity
// register; results over a valid/ready channel.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  i_in      in   valid/ready     mode, entry_id, entry_key
//  o_out     out  valid/ready     accepted, held_count, min_key, out_valid,
//                                 out_id, out_key, last
//  cfg       in   i_cfg_we only   i_cfg_data = capacity
//
//  With the sink ready an insert, clear or no-op item goes in every cycle,
//  since the compare-cell row writes all of its entries in parallel.
//  In a dump the sequencer reads the entries from the row, one entry per
//  cycle while the sink is ready. Input ready is low while a dump streams out.
//  Reset (synchronous, i_rst_n low) empties the list, zeroes the minimum and
//  sets capacity to 16; no clearing pass is needed.
//  A stalled result holds in the result register; outside a dump, input
//  ready drops only while that register is full and not being taken.
// ---------------------------------------------------------------------------
`default_nettype none

module top_k_tracker
    import tkt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    tkt_in_if.sink                i_in,
    tkt_out_if.source             o_out
);

    t_cmd    cmd;
    t_stat   stat;
    t_result result;

    // sequencer: mode decode, dump stepping, result valid
    tkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_mode      (i_in.mode),
        .o_ready     (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // entry row, counters and result register
    tkt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_id       (i_in.entry_id),
        .i_key      (i_in.entry_key),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (result)
    );

    assign o_out.accepted   = result.accepted;
    assign o_out.held_count = result.held_count;
    assign o_out.min_key    = result.min_key;
    assign o_out.out_valid  = result.out_valid;
    assign o_out.out_id     = result.out_id;
    assign o_out.out_key    = result.out_key;
    assign o_out.last       = result.last;

endmodule

`default_nettype wire
